[sv/rajhs_pkg.sv]
// Shared types, constants and helper functions for the rover arm jog/home sequencer.
package rajhs_pkg;

  localparam int JOINT_COUNT = 4;

  localparam int J_BASE     = 0;
  localparam int J_SHOULDER = 1;
  localparam int J_ELBOW    = 2;
  localparam int J_WRIST    = 3;

  // Homing interlock and target constants, in degrees.
  localparam int SHOULDER_STRAIN   = 55;
  localparam int WRIST_PARK        = -40;
  localparam int SHOULDER_OFFSET   = 30;
  localparam int ELBOW_SHOULDER_MIN = 20;
  localparam int WRIST_SHOULDER_MIN = 50;

  // Configuration reset values.
  localparam logic [10:0] DRIVE_STEP_RST  = 11'd100;
  localparam logic [11:0] DRIVE_LIMIT_RST = 12'd2000;
  localparam logic [3:0]  STEER_STEP_RST  = 4'd3;
  localparam logic [7:0]  ANGLE_LIMIT_RST = 8'd180;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVE_STEP  = 2'd0,
    CFG_DRIVE_LIMIT = 2'd1,
    CFG_STEER_STEP  = 2'd2,
    CFG_ANGLE_LIMIT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [10:0] drive_step;
    logic [11:0] drive_limit;
    logic [3:0]  steer_step;
    logic [7:0]  angle_limit;
  } cfg_t;

  // Stored angles reach +/-255 when the limit is set that high; they carry
  // one bit more than the 9-bit result fields.
  typedef logic signed [9:0]  angle_t;
  typedef logic signed [10:0] angle_sum_t;
  typedef logic signed [12:0] drive_t;
  typedef logic signed [13:0] drive_sum_t;

  function automatic angle_t clamp_angle(angle_sum_t v, logic [7:0] lim);
    angle_sum_t l;
    angle_sum_t nl;
    l  = {3'b000, lim};
    nl = -l;
    if (v > l) begin
      return l[9:0];
    end else if (v < nl) begin
      return nl[9:0];
    end
    return v[9:0];
  endfunction

  function automatic drive_t clamp_drive(drive_sum_t v, logic [11:0] lim);
    drive_sum_t l;
    drive_sum_t nl;
    l  = {2'b00, lim};
    nl = -l;
    if (v > l) begin
      return l[12:0];
    end else if (v < nl) begin
      return nl[12:0];
    end
    return v[12:0];
  endfunction

endpackage

[sv/rajhs_tick_if.sv]
// Request channel carrying one control tick of operator buttons.
interface rajhs_tick_if;
  logic       valid;
  logic       ready;
  logic [7:0] arm_buttons;
  logic       home_held;
  logic       vacuum_press;
  logic [2:0] steer_buttons;
  logic [2:0] drive_buttons;

  modport source (output valid, arm_buttons, home_held, vacuum_press, steer_buttons,
                  drive_buttons, input ready);
  modport sink (input valid, arm_buttons, home_held, vacuum_press, steer_buttons,
                drive_buttons, output ready);
endinterface

[sv/rajhs_result_if.sv]
// Request channel carrying the servo, vacuum and drive commands of one tick.
interface rajhs_result_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] base_angle;
  logic signed [8:0] shoulder_angle;
  logic signed [8:0] elbow_angle;
  logic signed [8:0] wrist_angle;
  logic              vacuum_on;
  logic signed [8:0] steer_angle;
  logic signed [12:0] drive_level;
  logic              arm_changed;
  logic              vacuum_changed;
  logic              steer_changed;
  logic              drive_changed;

  modport source (output valid, base_angle, shoulder_angle, elbow_angle, wrist_angle,
                  vacuum_on, steer_angle, drive_level, arm_changed, vacuum_changed,
                  steer_changed, drive_changed, input ready);
  modport sink (input valid, base_angle, shoulder_angle, elbow_angle, wrist_angle,
                vacuum_on, steer_angle, drive_level, arm_changed, vacuum_changed,
                steer_changed, drive_changed, output ready);
endinterface

[sv/rover_arm_jog_home_sequencer_top.sv]
// Top level of the rover arm jog/home sequencer.
//
// Each request on the tick channel is one control tick: held arm jog buttons,
// the return-home button, a one-shot vacuum toggle, steering and drive buttons.
// For every tick the block returns exactly one request on the result channel
// with the four joint angles, vacuum state, steering angle and drive level as
// they stand after the tick, plus one flag per group that acted this tick.
//
// A tick is captured in an input register; from there the homing pass,
// jogging, vacuum, steering and drive logic run as one short combinational
// path into the result register and the state registers. The result is offered
// from the result register once its tick has moved out of the input register.
// One tick is taken in every cycle while the receiver keeps up: the only
// feedback is the state register loop through that single stage.
//
// When the receiver stalls, the result register holds and the input register
// still takes one more tick; after that ready drops until the result moves.
// Reset (synchronous, active high) empties both registers, zeroes the joints,
// vacuum, steering and drive, and restores the default steps and limits.
module rover_arm_jog_home_sequencer_top import rajhs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rajhs_tick_if.sink            tick,
  rajhs_result_if.source        result
);

  // The core holds the configuration registers, the input register, the
  // per-tick logic and the result register.
  rajhs_top u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick),
    .result    (result)
  );

  // Reset leaves the result channel empty and the tick channel ready.
  assert property (@(posedge clk)
    rst |=> (!result.valid && tick.ready))
    else $error("block not empty after reset");

  // A stalled result stays offered and unchanged until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=>
      (result.valid && $stable(result.base_angle) && $stable(result.shoulder_angle) &&
       $stable(result.elbow_angle) && $stable(result.wrist_angle) &&
       $stable(result.vacuum_on) && $stable(result.steer_angle) &&
       $stable(result.drive_level)))
    else $error("stalled result changed or dropped");

  // With the result register empty, a tick is always taken.
  assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> tick.ready)
    else $error("tick channel stalled with no result waiting");

endmodule

[sv/rajhs_cfg.sv]
// Configuration register file for step sizes and saturation limits.
module rajhs_cfg import rajhs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_step  <= DRIVE_STEP_RST;
      cfg.drive_limit <= DRIVE_LIMIT_RST;
      cfg.steer_step  <= STEER_STEP_RST;
      cfg.angle_limit <= ANGLE_LIMIT_RST;
    end else if (wr_en) begin
      case (cfg_reg_e'(index))
        CFG_DRIVE_STEP:  cfg.drive_step  <= data[10:0];
        CFG_DRIVE_LIMIT: cfg.drive_limit <= data[11:0];
        CFG_STEER_STEP:  cfg.steer_step  <= data[3:0];
        CFG_ANGLE_LIMIT: cfg.angle_limit <= data[7:0];
        default: ;
      endcase
    end
  end

endmodule

[sv/rajhs_home.sv]
// One homing pass over the four joints, each seeing the joints updated before it.
module rajhs_home import rajhs_pkg::*; (
  input  angle_t     joints_in  [JOINT_COUNT],
  input  logic [7:0] angle_limit,
  output angle_t     joints_out [JOINT_COUNT]
);

  angle_t     a [JOINT_COUNT];
  angle_sum_t target;
  angle_sum_t delta;
  logic       strain;

  always_comb begin
    a      = joints_in;
    target = '0;
    delta  = '0;
    strain = 1'b0;
    for (int j = 0; j < JOINT_COUNT; j++) begin
      // While the shoulder is high and the wrist is not parked, only the wrist moves.
      strain = (a[J_SHOULDER] > SHOULDER_STRAIN) && (a[J_WRIST] != WRIST_PARK);
      if (!strain || j == J_WRIST) begin
        target = '0;
        if (j == J_SHOULDER && a[J_BASE] != 0) begin
          target = 11'(SHOULDER_OFFSET);
        end else if (j == J_ELBOW &&
                     (a[J_BASE] != 0 || a[J_SHOULDER] > ELBOW_SHOULDER_MIN)) begin
          target = {a[J_SHOULDER][9], a[J_SHOULDER]} + 11'(SHOULDER_OFFSET);
        end else if (j == J_WRIST && a[J_SHOULDER] > WRIST_SHOULDER_MIN) begin
          target = 11'(WRIST_PARK);
        end
        if ($signed({a[j][9], a[j]}) < target) begin
          delta = 11'sd1;
        end else if ($signed({a[j][9], a[j]}) > target) begin
          delta = -11'sd1;
        end else begin
          delta = '0;
        end
        // Base and wrist take double steps except next to zero.
        if ((j == J_BASE || j == J_WRIST) && a[j] != 1 && a[j] != -1) begin
          delta = delta <<< 1;
        end
        a[j] = clamp_angle({a[j][9], a[j]} + delta, angle_limit);
      end
    end
    joints_out = a;
  end

endmodule

[sv/rajhs_top.sv]
// Core of the rover arm jog/home sequencer: input register, tick logic and result register.
module rajhs_top import rajhs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rajhs_tick_if.sink            tick,
  rajhs_result_if.source        result
);

  cfg_t cfg;

  rajhs_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // Input register.
  logic       in_valid;
  logic [7:0] in_arm;
  logic       in_home;
  logic       in_vac;
  logic [2:0] in_steer;
  logic [2:0] in_drive;

  // Result register handshake.
  logic out_valid;
  logic advance;
  logic load;

  assign advance    = !out_valid || result.ready;
  assign load       = in_valid && advance;
  assign tick.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_arm   <= tick.arm_buttons;
      in_home  <= tick.home_held;
      in_vac   <= tick.vacuum_press;
      in_steer <= tick.steer_buttons;
      in_drive <= tick.drive_buttons;
    end
  end

  // Block state, updated once per tick as the tick moves into the result register.
  angle_t joints [JOINT_COUNT];
  logic   vacuum;
  angle_t steer_pos;
  drive_t drive_pos;

  angle_t homed [JOINT_COUNT];
  angle_t joints_next [JOINT_COUNT];
  logic   vacuum_next;
  angle_t steer_next;
  drive_t drive_next;
  logic   arm_chg;
  logic   steer_chg;
  logic   drive_chg;

  rajhs_home u_home (
    .joints_in   (joints),
    .angle_limit (cfg.angle_limit),
    .joints_out  (homed)
  );

  always_comb begin
    // Homing runs first, then the jog buttons act on what homing left.
    for (int j = 0; j < JOINT_COUNT; j++) begin
      joints_next[j] = in_home ? homed[j] : joints[j];
    end
    arm_chg = in_home;
    for (int j = 0; j < JOINT_COUNT; j++) begin
      if (in_arm[2*j]) begin
        joints_next[j] = clamp_angle({joints_next[j][9], joints_next[j]} + 11'sd1,
                                     cfg.angle_limit);
        arm_chg = 1'b1;
      end else if (in_arm[2*j+1]) begin
        joints_next[j] = clamp_angle({joints_next[j][9], joints_next[j]} - 11'sd1,
                                     cfg.angle_limit);
        arm_chg = 1'b1;
      end
    end

    vacuum_next = vacuum ^ in_vac;

    // Steering: up wins over down, and centre overrides either.
    steer_next = steer_pos;
    steer_chg  = 1'b0;
    if (in_steer[0]) begin
      steer_next = clamp_angle({steer_pos[9], steer_pos} + {7'b0, cfg.steer_step},
                               cfg.angle_limit);
      steer_chg  = 1'b1;
    end else if (in_steer[1]) begin
      steer_next = clamp_angle({steer_pos[9], steer_pos} - {7'b0, cfg.steer_step},
                               cfg.angle_limit);
      steer_chg  = 1'b1;
    end
    if (in_steer[2]) begin
      steer_next = '0;
      steer_chg  = 1'b1;
    end

    // Drive: forward wins over back, and stop overrides either.
    drive_next = drive_pos;
    drive_chg  = 1'b0;
    if (in_drive[0]) begin
      drive_next = clamp_drive({drive_pos[12], drive_pos} + {3'b0, cfg.drive_step},
                               cfg.drive_limit);
      drive_chg  = 1'b1;
    end else if (in_drive[1]) begin
      drive_next = clamp_drive({drive_pos[12], drive_pos} - {3'b0, cfg.drive_step},
                               cfg.drive_limit);
      drive_chg  = 1'b1;
    end
    if (in_drive[2]) begin
      drive_next = '0;
      drive_chg  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < JOINT_COUNT; j++) begin
        joints[j] <= '0;
      end
      vacuum    <= 1'b0;
      steer_pos <= '0;
      drive_pos <= '0;
    end else if (load) begin
      joints    <= joints_next;
      vacuum    <= vacuum_next;
      steer_pos <= steer_next;
      drive_pos <= drive_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.base_angle     <= joints_next[J_BASE][8:0];
      result.shoulder_angle <= joints_next[J_SHOULDER][8:0];
      result.elbow_angle    <= joints_next[J_ELBOW][8:0];
      result.wrist_angle    <= joints_next[J_WRIST][8:0];
      result.vacuum_on      <= vacuum_next;
      result.steer_angle    <= steer_next[8:0];
      result.drive_level    <= drive_next;
      result.arm_changed    <= arm_chg;
      result.vacuum_changed <= in_vac;
      result.steer_changed  <= steer_chg;
      result.drive_changed  <= drive_chg;
    end
  end

  assign result.valid = out_valid;

endmodule

[sim/tb.sv]
// Self-checking testbench for the rover arm jog/home sequencer top level.
module tb;
  import rajhs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // A run is declared hung when neither channel moves a request for this many
  // cycles. The longest legitimate quiet stretch is the receiver hold-off,
  // so this leaves a wide margin.
  localparam int HANG_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  // The block offers each result from its result register; these quiet
  // cycles make sure nothing is still in flight.
  localparam int SETTLE_CYCLES = 6;

  // One control tick as the operator console sends it.
  typedef struct {
    logic [7:0] arm_buttons;
    logic       home_held;
    logic       vacuum_press;
    logic [2:0] steer_buttons;
    logic [2:0] drive_buttons;
  } tick_item_t;

  // The servo, vacuum and drive commands that one tick produces.
  typedef struct {
    logic signed [8:0]  base_angle;
    logic signed [8:0]  shoulder_angle;
    logic signed [8:0]  elbow_angle;
    logic signed [8:0]  wrist_angle;
    logic               vacuum_on;
    logic signed [8:0]  steer_angle;
    logic signed [12:0] drive_level;
    logic               arm_changed;
    logic               vacuum_changed;
    logic               steer_changed;
    logic               drive_changed;
  } command_item_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rajhs_tick_if   tick_ch ();
  rajhs_result_if result_ch ();

  rover_arm_jog_home_sequencer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .result    (result_ch)
  );

  // Our own copy of the register settings, mirrored on every write.
  logic [10:0] set_drive_step;
  logic [11:0] set_drive_limit;
  logic [3:0]  set_steer_step;
  logic [7:0]  set_angle_limit;

  // Our own copy of the rover state, kept as plain integers.
  int joint_pos [JOINT_COUNT];
  bit vacuum_is_on;
  int steer_pos;
  int drive_pos;

  // Commands predicted for accepted ticks, oldest first.
  command_item_t pending_commands[$];
  int mismatch_count;

  // Idle percentages for both sides, and the receiver hold-off request.
  int send_idle_pct;
  int recv_idle_pct;
  int hold_seq;
  int hold_seen;
  int hold_left;
  int quiet_cycles;

  always #5 clk = ~clk;

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  function automatic int clip_sym(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // One homing pass. Joints move in order, and each joint sees what the
  // joints before it reached earlier in the same pass.
  function automatic void run_homing_pass();
    int target;
    int step;
    for (int j = 0; j < JOINT_COUNT; j++) begin
      // While the shoulder is strained and the wrist is not parked, only the
      // wrist may move.
      if (!(joint_pos[J_SHOULDER] > SHOULDER_STRAIN && joint_pos[J_WRIST] != WRIST_PARK &&
            j != J_WRIST)) begin
        target = 0;
        if (j == J_SHOULDER && joint_pos[J_BASE] != 0) begin
          target = SHOULDER_OFFSET;
        end else if (j == J_ELBOW &&
                     (joint_pos[J_BASE] != 0 || joint_pos[J_SHOULDER] > ELBOW_SHOULDER_MIN)) begin
          target = joint_pos[J_SHOULDER] + SHOULDER_OFFSET;
        end else if (j == J_WRIST && joint_pos[J_SHOULDER] > WRIST_SHOULDER_MIN) begin
          target = WRIST_PARK;
        end
        if (joint_pos[j] < target) step = 1;
        else if (joint_pos[j] > target) step = -1;
        else step = 0;
        // Base and wrist take double steps except right next to zero.
        if ((j == J_BASE || j == J_WRIST) && joint_pos[j] != 1 && joint_pos[j] != -1) begin
          step = step * 2;
        end
        joint_pos[j] = clip_sym(joint_pos[j] + step, int'(set_angle_limit));
      end
    end
  endfunction

  // Applies one tick to the rover state and returns the commands it yields.
  function automatic command_item_t advance_rover(tick_item_t t);
    command_item_t r;
    int alim;
    int dlim;
    logic [1:0] pair;
    bit arm_chg;
    bit steer_chg;
    bit drive_chg;
    alim = int'(set_angle_limit);
    dlim = int'(set_drive_limit);
    arm_chg = 1'b0;
    steer_chg = 1'b0;
    drive_chg = 1'b0;

    if (t.home_held) begin
      run_homing_pass();
      arm_chg = 1'b1;
    end

    // Increment wins over decrement on the same joint.
    for (int j = 0; j < JOINT_COUNT; j++) begin
      pair = t.arm_buttons[2*j +: 2];
      if (pair[0]) begin
        joint_pos[j] = clip_sym(joint_pos[j] + 1, alim);
        arm_chg = 1'b1;
      end else if (pair[1]) begin
        joint_pos[j] = clip_sym(joint_pos[j] - 1, alim);
        arm_chg = 1'b1;
      end
    end

    if (t.vacuum_press) vacuum_is_on = !vacuum_is_on;

    // Up wins over down; centre comes after the step.
    if (t.steer_buttons[0]) begin
      steer_pos = clip_sym(steer_pos + int'(set_steer_step), alim);
      steer_chg = 1'b1;
    end else if (t.steer_buttons[1]) begin
      steer_pos = clip_sym(steer_pos - int'(set_steer_step), alim);
      steer_chg = 1'b1;
    end
    if (t.steer_buttons[2]) begin
      steer_pos = 0;
      steer_chg = 1'b1;
    end

    // Forward wins over back; stop comes after the ramp.
    if (t.drive_buttons[0]) begin
      drive_pos = clip_sym(drive_pos + int'(set_drive_step), dlim);
      drive_chg = 1'b1;
    end else if (t.drive_buttons[1]) begin
      drive_pos = clip_sym(drive_pos - int'(set_drive_step), dlim);
      drive_chg = 1'b1;
    end
    if (t.drive_buttons[2]) begin
      drive_pos = 0;
      drive_chg = 1'b1;
    end

    r.base_angle     = joint_pos[J_BASE][8:0];
    r.shoulder_angle = joint_pos[J_SHOULDER][8:0];
    r.elbow_angle    = joint_pos[J_ELBOW][8:0];
    r.wrist_angle    = joint_pos[J_WRIST][8:0];
    r.vacuum_on      = vacuum_is_on;
    r.steer_angle    = steer_pos[8:0];
    r.drive_level    = drive_pos[12:0];
    r.arm_changed    = arm_chg;
    r.vacuum_changed = t.vacuum_press;
    r.steer_changed  = steer_chg;
    r.drive_changed  = drive_chg;
    return r;
  endfunction

  // Appends one prediction behind the ones still waiting.
  function automatic void queue_command(command_item_t c);
    pending_commands.insert(pending_commands.size(), c);
  endfunction

  // ------------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------------

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Every accepted result is held against the oldest prediction. The outputs
  // are sampled at the edge itself, before the block's own updates land.
  always @(posedge clk) begin
    command_item_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_commands.size() == 0) begin
        $error("result accepted with no tick outstanding");
        mismatch_count++;
      end else begin
        want = pending_commands.pop_front();
        check_field("base_angle", int'(want.base_angle), int'(result_ch.base_angle));
        check_field("shoulder_angle", int'(want.shoulder_angle),
                    int'(result_ch.shoulder_angle));
        check_field("elbow_angle", int'(want.elbow_angle), int'(result_ch.elbow_angle));
        check_field("wrist_angle", int'(want.wrist_angle), int'(result_ch.wrist_angle));
        check_field("vacuum_on", int'(want.vacuum_on), int'(result_ch.vacuum_on));
        check_field("steer_angle", int'(want.steer_angle), int'(result_ch.steer_angle));
        check_field("drive_level", int'(want.drive_level), int'(result_ch.drive_level));
        check_field("arm_changed", int'(want.arm_changed), int'(result_ch.arm_changed));
        check_field("vacuum_changed", int'(want.vacuum_changed),
                    int'(result_ch.vacuum_changed));
        check_field("steer_changed", int'(want.steer_changed), int'(result_ch.steer_changed));
        check_field("drive_changed", int'(want.drive_changed), int'(result_ch.drive_changed));
      end
    end
  end

  // The receiver stalls at random, except during a requested hold-off, which
  // it counts out by itself so that the sender keeps pushing meanwhile.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_OFF_CYCLES;
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hang detection: any accepted request on either channel restarts the count.
  always @(posedge clk) begin
    if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  // Offers one tick, with a random gap first, and waits for it to be taken.
  // Valid stays high after acceptance so that back-to-back ticks need no
  // extra edge; whoever comes next lowers it if needed.
  task automatic send_tick(tick_item_t t);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid         <= 1'b1;
    tick_ch.arm_buttons   <= t.arm_buttons;
    tick_ch.home_held     <= t.home_held;
    tick_ch.vacuum_press  <= t.vacuum_press;
    tick_ch.steer_buttons <= t.steer_buttons;
    tick_ch.drive_buttons <= t.drive_buttons;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    queue_command(advance_rover(t));
  endtask

  function automatic tick_item_t make_tick(logic [7:0] arm, logic home, logic vac,
                                           logic [2:0] steer, logic [2:0] drive);
    tick_item_t t;
    t.arm_buttons = arm;
    t.home_held = home;
    t.vacuum_press = vac;
    t.steer_buttons = steer;
    t.drive_buttons = drive;
    return t;
  endfunction

  // Stops offering ticks and waits until every predicted command has come
  // back and the pipeline has had time to go quiet.
  task automatic drain_commands();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_commands.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes are only issued with the block idle, so callers drain
  // first. An idle edge follows every write.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_DRIVE_STEP:  set_drive_step  = value[10:0];
      CFG_DRIVE_LIMIT: set_drive_limit = value[11:0];
      CFG_STEER_STEP:  set_steer_step  = value[3:0];
      CFG_ANGLE_LIMIT: set_angle_limit = value[7:0];
      default: ;
    endcase
  endtask

  task automatic configure_all(int dstep, int dlim, int sstep, int alim);
    drain_commands();
    write_reg(CFG_DRIVE_STEP, CFG_DATA_W'(dstep));
    write_reg(CFG_DRIVE_LIMIT, CFG_DATA_W'(dlim));
    write_reg(CFG_STEER_STEP, CFG_DATA_W'(sstep));
    write_reg(CFG_ANGLE_LIMIT, CFG_DATA_W'(alim));
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Quiet tick, all-joint jogs in both directions, both jog bits at once,
  // and the vacuum toggled on and off again.
  task automatic test_jog_and_vacuum();
    send_tick(make_tick(8'h00, 1'b0, 1'b0, 3'b000, 3'b000));
    send_tick(make_tick(8'h55, 1'b0, 1'b0, 3'b000, 3'b000));
    send_tick(make_tick(8'h55, 1'b0, 1'b0, 3'b000, 3'b000));
    send_tick(make_tick(8'hAA, 1'b0, 1'b0, 3'b000, 3'b000));
    send_tick(make_tick(8'hFF, 1'b0, 1'b1, 3'b000, 3'b000));
    send_tick(make_tick(8'hFF, 1'b0, 1'b1, 3'b000, 3'b000));
  endtask

  // Steering and drive: each direction, both directions held, centre/stop
  // alone and together with a step.
  task automatic test_steer_and_drive();
    send_tick(make_tick(8'h00, 1'b0, 1'b0, 3'b001, 3'b001));
    send_tick(make_tick(8'h00, 1'b0, 1'b0, 3'b010, 3'b010));
    send_tick(make_tick(8'h00, 1'b0, 1'b0, 3'b011, 3'b011));
    send_tick(make_tick(8'h00, 1'b0, 1'b0, 3'b100, 3'b100));
    send_tick(make_tick(8'h00, 1'b0, 1'b0, 3'b111, 3'b111));
  endtask

  // Offset the base so the shoulder and elbow get non-zero targets, then
  // hold home for a few passes.
  task automatic test_homing();
    send_tick(make_tick(8'h01, 1'b0, 1'b0, 3'b000, 3'b000));
    send_tick(make_tick(8'h01, 1'b0, 1'b0, 3'b000, 3'b000));
    repeat (5) send_tick(make_tick(8'h00, 1'b1, 1'b0, 3'b000, 3'b000));
  endtask

  // Tight limits and large steps, so steering and drive saturate in both
  // directions and the joints at their upper limit within a handful of ticks.
  task automatic test_saturation();
    configure_all(2000, 150, 15, 2);
    repeat (3) send_tick(make_tick(8'h55, 1'b0, 1'b0, 3'b001, 3'b001));
    repeat (3) send_tick(make_tick(8'hAA, 1'b0, 1'b0, 3'b010, 3'b010));
  endtask

  // Random ticks in bursts. Jog bursts push one joint far in one direction,
  // homing bursts hold home long enough for the sequence to play out, ramp
  // bursts run steering and drive into their limits, and noise bursts mix
  // every field freely.
  task automatic run_random_ticks(int count);
    tick_item_t t;
    int kind;
    int len;
    int joint;
    int dir;
    int sent;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 3);
      joint = $urandom_range(0, JOINT_COUNT - 1);
      dir = $urandom_range(0, 1);
      case (kind)
        0: len = $urandom_range(20, 120);
        1: len = $urandom_range(10, 80);
        2: len = $urandom_range(5, 20);
        default: len = $urandom_range(10, 60);
      endcase
      for (int k = 0; k < len && sent < count; k++) begin
        t = make_tick(8'($urandom), 1'($urandom), 1'($urandom), 3'($urandom),
                      3'($urandom));
        case (kind)
          0: begin
            if ($urandom_range(7) != 0) t.arm_buttons = 8'(1 << (2 * joint + dir));
            t.home_held = ($urandom_range(15) == 0);
            t.vacuum_press = ($urandom_range(15) == 0);
          end
          1: begin
            t.home_held = 1'b1;
            if ($urandom_range(9) != 0) t.arm_buttons = 8'h00;
            t.vacuum_press = ($urandom_range(15) == 0);
          end
          2: ;
          default: begin
            if ($urandom_range(11) != 0) t.steer_buttons = 3'(1 << dir);
            if ($urandom_range(11) != 0) t.drive_buttons = 3'(1 << (1 - dir));
            if ($urandom_range(3) != 0) t.arm_buttons = 8'h00;
            t.home_held = ($urandom_range(15) == 0);
          end
        endcase
        send_tick(t);
        sent++;
      end
    end
  endtask

  // The receiver holds off for a long stretch while the sender offers ticks
  // without gaps, so the block fills up and has to stall its input.
  task automatic test_backpressure();
    int saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    hold_seq = hold_seq + 1;
    run_random_ticks(60);
    send_idle_pct = saved_pct;
    drain_commands();
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_DRIVE_STEP;
    cfg_data <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.arm_buttons <= '0;
    tick_ch.home_held <= 1'b0;
    tick_ch.vacuum_press <= 1'b0;
    tick_ch.steer_buttons <= '0;
    tick_ch.drive_buttons <= '0;
    hold_seq = 0;
    hold_seen = 0;
    hold_left = 0;
    quiet_cycles = 0;
    mismatch_count = 0;

    // The predictor starts from the block's reset state.
    set_drive_step  = DRIVE_STEP_RST;
    set_drive_limit = DRIVE_LIMIT_RST;
    set_steer_step  = STEER_STEP_RST;
    set_angle_limit = ANGLE_LIMIT_RST;
    for (int j = 0; j < JOINT_COUNT; j++) joint_pos[j] = 0;
    vacuum_is_on = 1'b0;
    steer_pos = 0;
    drive_pos = 0;

    // First phase: the sender idles now and then, the receiver mostly.
    send_idle_pct = 14;
    recv_idle_pct = 84;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_jog_and_vacuum();
    test_steer_and_drive();
    test_homing();
    test_saturation();

    // Back to the default settings for a long random run.
    configure_all(int'(DRIVE_STEP_RST), int'(DRIVE_LIMIT_RST), int'(STEER_STEP_RST),
                  int'(ANGLE_LIMIT_RST));
    run_random_ticks(450);
    test_backpressure();

    // Second phase: the roles swap, the sender is the slow side.
    send_idle_pct = 84;
    recv_idle_pct = 14;
    configure_all(2000, 4095, 15, 180);
    run_random_ticks(450);
    // Everything at zero; values left from the previous phase get clamped
    // down at their next update.
    configure_all(0, 0, 0, 0);
    run_random_ticks(150);

    // Third phase: neither side idles.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure_all($urandom_range(0, 2000), $urandom_range(0, 4095),
                  $urandom_range(0, 15), $urandom_range(0, 180));
    run_random_ticks(400);
    configure_all($urandom_range(1, 400), $urandom_range(100, 1500),
                  $urandom_range(1, 15), $urandom_range(30, 70));
    run_random_ticks(300);

    drain_commands();

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
